[src/dfiu_pkg.sv]
// ----------------------------------------------------------------------------
// dfiu_pkg
// Types, codes and geometry constants shared by the frame item unpacker.
// ----------------------------------------------------------------------------
package dfiu_pkg;

   // board geometry
   localparam int CHIP_COUNT    = 4;
   localparam int CHANNEL_COUNT = 68;
   localparam int BUCKET_COUNT  = 512;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // request action codes
   localparam logic ACTION_START = 1'b0;
   localparam logic ACTION_WORD  = 1'b1;

   // response kind codes
   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // frame types from the header
   localparam logic [15:0] FRAME_PARTIAL = 16'd1;
   localparam logic [15:0] FRAME_FULL    = 16'd2;

   typedef struct packed {
      logic        action;
      logic [15:0] frame_type;
      logic [31:0] event_id;
      logic [47:0] event_time;
      logic [31:0] data_word;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  chip_index;
      logic [6:0]  channel_index;
      logic [8:0]  bucket_index;
      logic [11:0] sample_value;
      logic [47:0] time_since_last;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_REPORT,
      CMD_SINGLE,
      CMD_PAIR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [1:0]  chip;
      logic [6:0]  channel;
      logic [8:0]  bucket;
      logic [11:0] sample_a;
      logic [11:0] sample_b;
      logic [47:0] delta;
   } cmd_type;

endpackage

[src/daq_frame_item_unpacker_unit.sv]
// ----------------------------------------------------------------------------
// daq_frame_item_unpacker_unit
// Frame item unpacker for one front-end board, queue style on both sides.
// ----------------------------------------------------------------------------
// A request is taken in every cycle in which the four-entry command queue has
// room, also while a response waits to be popped. A frame start gives one
// report with the time since the previous frame, a partial-mode word one
// sample, a full-mode word two samples (channel c, then c+1); other words are
// dropped. The output register delivers one response per cycle while pop is
// held high. A response passes through the command queue and then the output
// register before it is on the ports.
module daq_frame_item_unpacker_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  dfiu_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dfiu_pkg::rsp_type rsp_data
);

   logic                    accept;
   logic                    cmd_push;
   logic                    q_full;
   dfiu_pkg::cmd_type       cmd;
   dfiu_pkg::cmd_type       head;
   logic                    head_empty;
   logic                    head_pop;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   dfiu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   dfiu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (head_pop),
      .head      (head),
      .empty     (head_empty),
      .full      (q_full)
   );

   dfiu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   // the front never issues into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !q_full)
      else $error("command issued into full queue");

   // first half of a pair is followed at once by its neighbor channel
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_data.last) |=>
      (!rsp_empty && rsp_data.kind == dfiu_pkg::KIND_SAMPLE && rsp_data.last &&
       rsp_data.channel_index == 7'($past(rsp_data.channel_index) + 7'd1)))
      else $error("pair second half missing or misplaced");

   // a frame report always closes its request
   a_report_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.kind == dfiu_pkg::KIND_REPORT) |-> rsp_data.last)
      else $error("frame report without last");

endmodule

[src/dfiu_front.sv]
// ----------------------------------------------------------------------------
// dfiu_front
// Classifies requests, keeps the frame state and issues commands.
// ----------------------------------------------------------------------------
module dfiu_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  dfiu_pkg::req_type req,
   output logic              cmd_push,
   output dfiu_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      MODE_IGNORE,
      MODE_PARTIAL,
      MODE_FULL
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [47:0] prev_time_ff, prev_time_in;
   logic [1:0]  chip_ff, chip_in;
   logic [6:0]  chan_ff, chan_in;
   logic [8:0]  bucket_ff, bucket_in;
   logic        done_ff, done_in;

   logic [2:0]  chip_sum;
   logic [7:0]  chan_sum;
   logic [9:0]  bucket_sum;
   logic [47:0] delta;
   logic [31:0] w;

   assign w = req.data_word;

   always_comb begin
      mode_in      = mode_ff;
      prev_time_in = prev_time_ff;
      chip_in      = chip_ff;
      chan_in      = chan_ff;
      bucket_in    = bucket_ff;
      done_in      = done_ff;
      cmd_push     = 1'b0;
      cmd          = '0;
      cmd.op       = dfiu_pkg::CMD_REPORT;

      delta = req.event_time - prev_time_ff;
      if (req.event_id == 32'd0) begin
         delta = '0;
      end

      chip_sum   = {1'b0, chip_ff} + 3'd1;
      chan_sum   = {1'b0, chan_ff} + 8'd2;
      bucket_sum = {1'b0, bucket_ff} + 10'd1;

      if (req.action == dfiu_pkg::ACTION_START) begin
         cmd_push = accept;
         cmd.op   = dfiu_pkg::CMD_REPORT;
         cmd.delta = delta;
         if (accept) begin
            prev_time_in = req.event_time;
            if (req.frame_type == dfiu_pkg::FRAME_PARTIAL) begin
               mode_in = MODE_PARTIAL;
            end else if (req.frame_type == dfiu_pkg::FRAME_FULL) begin
               mode_in = MODE_FULL;
            end else begin
               mode_in = MODE_IGNORE;
            end
            chip_in   = '0;
            chan_in   = '0;
            bucket_in = '0;
            done_in   = 1'b0;
         end
      end else if (mode_ff == MODE_PARTIAL) begin
         cmd_push     = accept;
         cmd.op       = dfiu_pkg::CMD_SINGLE;
         cmd.chip     = w[7:6];
         cmd.channel  = {w[5:0], w[15]};
         cmd.bucket   = {w[14:8], w[23:22]};
         cmd.sample_a = {w[19:16], w[31:24]};
      end else if (mode_ff == MODE_FULL && !done_ff) begin
         cmd_push     = accept;
         cmd.op       = dfiu_pkg::CMD_PAIR;
         cmd.chip     = chip_ff;
         cmd.channel  = chan_ff;
         cmd.bucket   = bucket_ff;
         cmd.sample_a = {w[3:0], w[15:8]};
         cmd.sample_b = {w[19:16], w[31:24]};
         if (accept) begin
            // chip innermost, then channel pairs, then buckets
            if (chip_sum >= 3'(dfiu_pkg::CHIP_COUNT)) begin
               chip_in = '0;
               if (chan_sum >= 8'(dfiu_pkg::CHANNEL_COUNT)) begin
                  chan_in = '0;
                  if (bucket_sum >= 10'(dfiu_pkg::BUCKET_COUNT)) begin
                     bucket_in = '0;
                     done_in   = 1'b1;
                  end else begin
                     bucket_in = bucket_sum[8:0];
                  end
               end else begin
                  chan_in = chan_sum[6:0];
               end
            end else begin
               chip_in = chip_sum[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IGNORE;
         prev_time_ff <= '0;
         chip_ff      <= '0;
         chan_ff      <= '0;
         bucket_ff    <= '0;
         done_ff      <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         prev_time_ff <= prev_time_in;
         chip_ff      <= chip_in;
         chan_ff      <= chan_in;
         bucket_ff    <= bucket_in;
         done_ff      <= done_in;
      end
   end

endmodule

[src/dfiu_queue.sv]
// ----------------------------------------------------------------------------
// dfiu_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dfiu_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  dfiu_pkg::cmd_type       push_data,
   input  logic                    pop,
   output dfiu_pkg::cmd_type       head,
   output logic                    empty,
   output logic                    full
);

   dfiu_pkg::cmd_type                store_ff [dfiu_pkg::QUEUE_DEPTH];
   logic [dfiu_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [dfiu_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [dfiu_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (dfiu_pkg::QUEUE_AW+1)'(dfiu_pkg::QUEUE_DEPTH));
   assign head    = store_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + (dfiu_pkg::QUEUE_AW)'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + (dfiu_pkg::QUEUE_AW)'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (dfiu_pkg::QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (dfiu_pkg::QUEUE_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/dfiu_back.sv]
// ----------------------------------------------------------------------------
// dfiu_back
// Expands queued commands into responses through an output register.
// ----------------------------------------------------------------------------
module dfiu_back (
   input  logic              clock,
   input  logic              reset,
   input  dfiu_pkg::cmd_type head,
   input  logic              head_empty,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output dfiu_pkg::rsp_type rsp_data
);

   dfiu_pkg::rsp_type out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   dfiu_pkg::rsp_type pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              out_free;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || rsp_pop;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      head_pop      = 1'b0;

      if (out_free) begin
         if (pend_valid_ff) begin
            // second sample of a full-mode pair
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (!head_empty) begin
            head_pop     = 1'b1;
            out_valid_in = 1'b1;
            out_in       = '0;
            unique case (head.op)
               dfiu_pkg::CMD_REPORT: begin
                  out_in.kind            = dfiu_pkg::KIND_REPORT;
                  out_in.time_since_last = head.delta;
                  out_in.last            = 1'b1;
               end
               dfiu_pkg::CMD_SINGLE: begin
                  out_in.kind          = dfiu_pkg::KIND_SAMPLE;
                  out_in.chip_index    = head.chip;
                  out_in.channel_index = head.channel;
                  out_in.bucket_index  = head.bucket;
                  out_in.sample_value  = head.sample_a;
                  out_in.last          = 1'b1;
               end
               dfiu_pkg::CMD_PAIR: begin
                  out_in.kind          = dfiu_pkg::KIND_SAMPLE;
                  out_in.chip_index    = head.chip;
                  out_in.channel_index = head.channel;
                  out_in.bucket_index  = head.bucket;
                  out_in.sample_value  = head.sample_a;
                  out_in.last          = 1'b0;
                  pend_in               = '0;
                  pend_in.kind          = dfiu_pkg::KIND_SAMPLE;
                  pend_in.chip_index    = head.chip;
                  pend_in.channel_index = head.channel + 7'd1;
                  pend_in.bucket_index  = head.bucket;
                  pend_in.sample_value  = head.sample_b;
                  pend_in.last          = 1'b1;
                  pend_valid_in         = 1'b1;
               end
               default: begin
                  out_valid_in = 1'b0;
               end
            endcase
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

endmodule

[tb/daq_frame_item_unpacker_unit_tb.sv]
// ----------------------------------------------------------------------------
// daq_frame_item_unpacker_unit_tb
// Self-checking bench for the frame item unpacker. Frame starts and data words
// are pushed in random bursts while the response side pops on a shifting stall
// pattern. A scoreboard decodes every accepted request on its own and checks
// each popped response, field by field, in order. A directed opening covers
// field extremes and every frame type, and a random stretch of well-formed
// frames and noise follows.
// ----------------------------------------------------------------------------
class unpacker_scoreboard;
   typedef enum {MODE_IGNORE, MODE_PARTIAL, MODE_FULL} frame_mode_type;

   dfiu_pkg::rsp_type unpacked_queue[$];
   logic [47:0]       prev_event_time;
   frame_mode_type    mode;
   int unsigned       chip_cnt;
   int unsigned       chan_cnt;
   int unsigned       bucket_cnt;
   bit                frame_over;
   int                errors;

   function new();
      prev_event_time = '0;
      mode            = MODE_IGNORE;
      chip_cnt        = 0;
      chan_cnt        = 0;
      bucket_cnt      = 0;
      frame_over      = 1'b0;
      errors          = 0;
   endfunction

   function void report(string msg);
      if (errors < 200) $display("mismatch: %s", msg);
      errors++;
   endfunction

   function int pending();
      return unpacked_queue.size();
   endfunction

   // decode one accepted request into the responses it should produce
   function void note_item(dfiu_pkg::req_type item);
      dfiu_pkg::rsp_type e;
      logic [31:0]       w;
      w = item.data_word;
      e = '0;
      e.kind = dfiu_pkg::KIND_SAMPLE;
      if (item.action == dfiu_pkg::ACTION_START) begin
         e.kind = dfiu_pkg::KIND_REPORT;
         e.time_since_last = (item.event_id == 0) ? 48'd0
                                                  : item.event_time - prev_event_time;
         e.last = 1'b1;
         unpacked_queue.push_back(e);
         prev_event_time = item.event_time;
         if (item.frame_type == dfiu_pkg::FRAME_PARTIAL) mode = MODE_PARTIAL;
         else if (item.frame_type == dfiu_pkg::FRAME_FULL) mode = MODE_FULL;
         else mode = MODE_IGNORE;
         chip_cnt   = 0;
         chan_cnt   = 0;
         bucket_cnt = 0;
         frame_over = 1'b0;
      end else if (mode == MODE_PARTIAL) begin
         e.chip_index    = w[7:6];
         e.channel_index = {w[5:0], w[15]};
         e.bucket_index  = {w[14:8], w[23:22]};
         e.sample_value  = {w[19:16], w[31:24]};
         e.last          = 1'b1;
         unpacked_queue.push_back(e);
      end else if (mode == MODE_FULL && !frame_over) begin
         e.chip_index    = 2'(chip_cnt);
         e.channel_index = 7'(chan_cnt);
         e.bucket_index  = 9'(bucket_cnt);
         e.sample_value  = {w[3:0], w[15:8]};
         e.last          = 1'b0;
         unpacked_queue.push_back(e);
         e.channel_index = 7'(chan_cnt + 1);
         e.sample_value  = {w[19:16], w[31:24]};
         e.last          = 1'b1;
         unpacked_queue.push_back(e);
         // chip innermost, then channel pairs, then buckets
         chip_cnt++;
         if (chip_cnt >= dfiu_pkg::CHIP_COUNT) begin
            chip_cnt = 0;
            chan_cnt += 2;
            if (chan_cnt >= dfiu_pkg::CHANNEL_COUNT) begin
               chan_cnt = 0;
               bucket_cnt++;
               if (bucket_cnt >= dfiu_pkg::BUCKET_COUNT) begin
                  bucket_cnt = 0;
                  frame_over = 1'b1;
               end
            end
         end
      end
   endfunction

   function void compare_field(string name, logic [47:0] got, logic [47:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
   endfunction

   function void check_unpacked(dfiu_pkg::rsp_type got);
      dfiu_pkg::rsp_type want;
      if (unpacked_queue.size() == 0) begin
         report($sformatf("response %0h with nothing expected", got));
         return;
      end
      want = unpacked_queue.pop_front();
      compare_field("kind", got.kind, want.kind);
      compare_field("chip_index", got.chip_index, want.chip_index);
      compare_field("channel_index", got.channel_index, want.channel_index);
      compare_field("bucket_index", got.bucket_index, want.bucket_index);
      compare_field("sample_value", got.sample_value, want.sample_value);
      compare_field("time_since_last", got.time_since_last, want.time_since_last);
      compare_field("last", got.last, want.last);
   endfunction
endclass

module daq_frame_item_unpacker_unit_tb;
   localparam int IDLE_LIMIT = 4000;
   localparam int ITEM_COUNT = 1250;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   dfiu_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   dfiu_pkg::rsp_type rsp_data;

   logic [15:0] pop_pattern = 16'hFFFF;
   int          pattern_age = 0;
   int          burst_left  = 0;
   int          idle_cycles = 0;
   int          items_sent  = 0;

   unpacker_scoreboard sb = new();

   daq_frame_item_unpacker_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
   endfunction

   function automatic dfiu_pkg::req_type make_start(logic [15:0] ftype, logic [31:0] id,
                                                    logic [47:0] etime);
      dfiu_pkg::req_type r;
      r.action     = dfiu_pkg::ACTION_START;
      r.frame_type = ftype;
      r.event_id   = id;
      r.event_time = etime;
      r.data_word  = $urandom;
      return r;
   endfunction

   // fields other than the word are junk for a data word
   function automatic dfiu_pkg::req_type make_word(logic [31:0] w);
      dfiu_pkg::req_type r;
      r.action     = dfiu_pkg::ACTION_WORD;
      r.frame_type = 16'($urandom);
      r.event_id   = $urandom;
      r.event_time = rand48();
      r.data_word  = w;
      return r;
   endfunction

   // push one request; bursts of random length separated by random gaps
   task automatic send_item(dfiu_pkg::req_type item);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      sb.note_item(item);
      items_sent++;
   endtask

   // receiver stalls follow a rotating pattern, reloaded at random whenever pattern_age wraps
   always @(posedge clock) begin
      if (pattern_age == 63) begin
         case ($urandom_range(0, 3))
            0:       pop_pattern <= 16'hFFFF;
            1:       pop_pattern <= 16'($urandom);
            2:       pop_pattern <= 16'($urandom & $urandom);
            default: pop_pattern <= ~16'($urandom & $urandom);
         endcase
         pattern_age <= 0;
      end else begin
         pop_pattern <= {pop_pattern[0], pop_pattern[15:1]};
         pattern_age <= pattern_age + 1;
      end
      rsp_pop <= pop_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_unpacked(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[daq_frame_item_unpacker_unit] ERROR");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      int                n_words;
      int                pick;
      logic [15:0]       ftype;
      logic [31:0]       id;
      dfiu_pkg::req_type r;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_item(make_word(32'hFFFF_FFFF));                  // no frame yet
      send_item(make_start(dfiu_pkg::FRAME_PARTIAL, 32'd0, 48'hFFFF_FFFF_FFFF));
      send_item(make_word(32'h0000_0000));
      send_item(make_word(32'hFFFF_FFFF));
      send_item(make_word(32'h0F00_803F));
      send_item(make_word(32'hF0C0_7FC0));
      send_item(make_start(dfiu_pkg::FRAME_FULL, 32'd1, 48'd0));      // time wraps
      send_item(make_word(32'h0000_0000));
      send_item(make_word(32'hFFFF_FFFF));
      send_item(make_word(32'h1234_5678));
      send_item(make_word(32'h0F0F_0F0F));
      send_item(make_word(32'hF0F0_F0F0));
      send_item(make_start(dfiu_pkg::FRAME_FULL, 32'hFFFF_FFFF, 48'd5));
      send_item(make_word($urandom));
      send_item(make_start(16'd0, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_item(make_word($urandom));
      send_item(make_start(16'd3, 32'h8000_0000, 48'h8000_0000_0000));
      send_item(make_word($urandom));
      send_item(make_start(16'hFFFF, 32'd7, 48'h0000_0000_0001));
      send_item(make_word($urandom));
      send_item(make_start(dfiu_pkg::FRAME_PARTIAL, 32'd2, 48'h7FFF_FFFF_FFFF));
      send_item(make_word($urandom));
      send_item(make_start(dfiu_pkg::FRAME_FULL, 32'd0, 48'd0));

      // random frames with noise mixed in
      while (items_sent < ITEM_COUNT) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            if (pick < 40) ftype = dfiu_pkg::FRAME_PARTIAL;
            else if (pick < 78) ftype = dfiu_pkg::FRAME_FULL;
            else ftype = 16'($urandom);
            id = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom);
            if ($urandom_range(0, 3) == 0)
               send_item(make_start(ftype, id,
                                    sb.prev_event_time + 48'($urandom_range(0, 255))));
            else
               send_item(make_start(ftype, id, rand48()));
            n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(0, 40);
            for (int i = 0; i < n_words && items_sent < ITEM_COUNT; i++)
               send_item(make_word($urandom));
         end else begin
            r = make_word($urandom);
            r.action = 1'($urandom);
            send_item(r);
         end
      end

      req_push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[daq_frame_item_unpacker_unit] OK");
      end else begin
         $display("[daq_frame_item_unpacker_unit] ERROR");
      end
      $finish;
   end
endmodule

[filelist.f]
src/dfiu_pkg.sv
src/dfiu_front.sv
src/dfiu_queue.sv
src/dfiu_back.sv
src/daq_frame_item_unpacker_unit.sv
tb/daq_frame_item_unpacker_unit_tb.sv
